// ===== sv/rcwc_pkg.sv =====
// Shared types, constants and codes for the RGB color window classifier.
`default_nettype none

package rcwc_pkg;

   localparam int RAW_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int REF_W       = 24;
   localparam int MARGIN_W    = 8;
   localparam int OUT_NORM_W  = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CHANNELS    = 3;
   localparam int REM_W       = RAW_W + BYTE_W;
   // widest window bound: 255 * (256 + 255)
   localparam int BOUND_W     = 17;
   localparam int MAX_REFERENCES = 6;

   localparam int NUM_REFERENCES_DEF = 6;
   localparam int NORM_BITS_DEF      = 10;

   // floor(clear * 9 / 10) = (clear * DIV_RECIP) >> DIV_SHIFT, exact for 16-bit clear
   localparam int RECIP_W   = 23;
   localparam int DIV_SHIFT = 23;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd7549749;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd77;

   typedef logic [REF_W-1:0] ref_type;

   localparam ref_type REF_RESET [MAX_REFERENCES] = '{
      24'hAA4C33, 24'h827133, 24'h566C55, 24'h4B9644, 24'h2A6C91, 24'h4F6C61
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MARGIN = 3'd0,
      REG_ORANGE = 3'd1,
      REG_YELLOW = 3'd2,
      REG_WHITE  = 3'd3,
      REG_GREEN  = 3'd4,
      REG_BLUE   = 3'd5,
      REG_BLACK  = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      CLS_NONE   = 3'd0,
      CLS_ORANGE = 3'd1,
      CLS_YELLOW = 3'd2,
      CLS_WHITE  = 3'd3,
      CLS_GREEN  = 3'd4,
      CLS_BLUE   = 3'd5,
      CLS_BLACK  = 3'd6
   } class_type;

   localparam class_type CLASS_CODE [MAX_REFERENCES] = '{
      CLS_ORANGE, CLS_YELLOW, CLS_WHITE, CLS_GREEN, CLS_BLUE, CLS_BLACK
   };

   typedef struct packed {
      logic                valid;
      logic                zero;
      logic [CHANNELS-1:0] sat;
   } cell_ctl_type;

   typedef struct packed {
      class_type               color_class;
      logic [OUT_NORM_W-1:0]   norm_red;
      logic [OUT_NORM_W-1:0]   norm_green;
      logic [OUT_NORM_W-1:0]   norm_blue;
      logic                    zero_divisor;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== sv/rcwc_div_cell.sv =====
// One divider cell: resolves one quotient bit for all three color lanes.
`default_nettype none

module rcwc_div_cell #(
   parameter int NORM_BITS = rcwc_pkg::NORM_BITS_DEF,
   parameter int STEP      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  rcwc_pkg::cell_ctl_type        up_ctl,
   input  logic [rcwc_pkg::RAW_W-1:0]    up_divisor,
   input  logic [rcwc_pkg::REM_W-1:0]    up_rem [rcwc_pkg::CHANNELS],
   input  logic [NORM_BITS-1:0]          up_quot [rcwc_pkg::CHANNELS],
   output rcwc_pkg::cell_ctl_type        dn_ctl,
   output logic [rcwc_pkg::RAW_W-1:0]    dn_divisor,
   output logic [rcwc_pkg::REM_W-1:0]    dn_rem [rcwc_pkg::CHANNELS],
   output logic [NORM_BITS-1:0]          dn_quot [rcwc_pkg::CHANNELS]
);
   import rcwc_pkg::*;

   localparam int SHW = RAW_W + NORM_BITS;

   logic [SHW-1:0]       shifted_div;
   logic [SHW-1:0]       rem_ext [CHANNELS];
   logic [SHW-1:0]       diff    [CHANNELS];
   logic [CHANNELS-1:0]  take;

   cell_ctl_type         ctl_ff;
   logic [RAW_W-1:0]     divisor_ff;
   logic [REM_W-1:0]     rem_ff  [CHANNELS];
   logic [REM_W-1:0]     rem_in  [CHANNELS];
   logic [NORM_BITS-1:0] quot_ff [CHANNELS];
   logic [NORM_BITS-1:0] quot_in [CHANNELS];

   always_comb begin
      shifted_div = SHW'(up_divisor) << STEP;
      for (int c = 0; c < CHANNELS; c++) begin
         rem_ext[c] = SHW'(up_rem[c]);
         take[c]    = rem_ext[c] >= shifted_div;
         diff[c]    = rem_ext[c] - shifted_div;
         rem_in[c]  = take[c] ? REM_W'(diff[c]) : up_rem[c];
         quot_in[c] = up_quot[c];
         quot_in[c][STEP] = take[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         divisor_ff <= up_divisor;
         rem_ff     <= rem_in;
         quot_ff    <= quot_in;
      end
   end

   assign dn_ctl     = ctl_ff;
   assign dn_divisor = divisor_ff;
   assign dn_rem     = rem_ff;
   assign dn_quot    = quot_ff;

endmodule

`default_nettype wire

// ===== sv/rcwc_match.sv =====
// Window test of the normalized channels against the reference colors, in priority order.
`default_nettype none

module rcwc_match #(
   parameter int NUM_REFERENCES = rcwc_pkg::NUM_REFERENCES_DEF,
   parameter int NORM_BITS      = rcwc_pkg::NORM_BITS_DEF
) (
   input  logic [NORM_BITS-1:0]          norm [rcwc_pkg::CHANNELS],
   input  logic [rcwc_pkg::BOUND_W-1:0]  bound_lo [NUM_REFERENCES][rcwc_pkg::CHANNELS],
   input  logic [rcwc_pkg::BOUND_W-1:0]  bound_hi [NUM_REFERENCES][rcwc_pkg::CHANNELS],
   output rcwc_pkg::class_type           color_class
);
   import rcwc_pkg::*;

   localparam int CW = NORM_BITS + BYTE_W;

   logic [CW-1:0]             scaled [CHANNELS];
   logic [NUM_REFERENCES-1:0] hit;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         scaled[c] = {norm[c], {BYTE_W{1'b0}}};
      end
      for (int i = 0; i < NUM_REFERENCES; i++) begin
         hit[i] = 1'b1;
         for (int c = 0; c < CHANNELS; c++) begin
            if (CW'(bound_lo[i][c]) > scaled[c] || scaled[c] > CW'(bound_hi[i][c])) begin
               hit[i] = 1'b0;
            end
         end
      end
   end

   // lowest index wins
   always_comb begin
      color_class = CLS_NONE;
      for (int i = NUM_REFERENCES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            color_class = CLASS_CODE[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/rgb_color_window_classifier.sv =====
// Top level: normalizes a color sensor reading and classifies it against reference colors.
//
// Usage:
//   req_* carries one raw reading (red, green, blue, clear counts); it is taken at a
//   clock edge where req_valid is high and req_stall is low. rsp_* returns one word per
//   reading, in order: color class, normalized red/green/blue and a zero-divisor flag.
//   csr_* writes the margin (index 0) and the six reference colors (indexes 1..6);
//   csr_ready is always high, writes belong to idle periods.
// Path: a taken reading passes the input stage, reciprocal multiply for the divisor,
//   setup stage, one divider cell per quotient bit, match stage and output register.
// Throughput: one reading per cycle while req_stall is low; the divider is a chain
//   of NORM_BITS cells that each resolve one quotient bit of all three channels.
// Reset: synchronous; empties the pipeline and loads the default margin and references.
// Stall: when rsp_stall holds a word, the next finished word drops into a skid
//   register and req_stall rises in the same cycle; the whole pipeline then holds
//   until the skid drains.
`default_nettype none

module rgb_color_window_classifier #(
   parameter int NUM_REFERENCES = rcwc_pkg::NUM_REFERENCES_DEF,
   parameter int NORM_BITS      = rcwc_pkg::NORM_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rcwc_pkg::RAW_W-1:0]         req_raw_red,
   input  logic [rcwc_pkg::RAW_W-1:0]         req_raw_green,
   input  logic [rcwc_pkg::RAW_W-1:0]         req_raw_blue,
   input  logic [rcwc_pkg::RAW_W-1:0]         req_raw_clear,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_color_class,
   output logic [rcwc_pkg::OUT_NORM_W-1:0]    rsp_norm_red,
   output logic [rcwc_pkg::OUT_NORM_W-1:0]    rsp_norm_green,
   output logic [rcwc_pkg::OUT_NORM_W-1:0]    rsp_norm_blue,
   output logic                               rsp_zero_divisor,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcwc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rcwc_pkg::REF_W-1:0]         csr_data
);
   import rcwc_pkg::*;

   localparam int SHW = RAW_W + NORM_BITS;

   // configuration
   logic [MARGIN_W-1:0] margin_ff;
   ref_type             ref_ff [NUM_REFERENCES];
   logic [8:0]          scale_lo;
   logic [8:0]          scale_hi;
   logic [BOUND_W-1:0]  lo_in  [NUM_REFERENCES][CHANNELS];
   logic [BOUND_W-1:0]  hi_in  [NUM_REFERENCES][CHANNELS];
   logic [BOUND_W-1:0]  lo_ff  [NUM_REFERENCES][CHANNELS];
   logic [BOUND_W-1:0]  hi_ff  [NUM_REFERENCES][CHANNELS];

   // pipeline
   logic                advance;
   logic                s0_valid_ff;
   logic [RAW_W-1:0]    s0_chan_ff [CHANNELS];
   logic [RAW_W-1:0]    s0_clear_ff;
   logic [RAW_W+RECIP_W-1:0] div_prod;
   logic                s1_valid_ff;
   logic [RAW_W-1:0]    s1_chan_ff [CHANNELS];
   logic [RAW_W-1:0]    s1_divisor_ff;
   cell_ctl_type        s2_ctl_in;
   cell_ctl_type        s2_ctl_ff;
   logic [RAW_W-1:0]    s2_divisor_ff;
   logic [REM_W-1:0]    s2_rem_in [CHANNELS];
   logic [REM_W-1:0]    s2_rem_ff [CHANNELS];

   cell_ctl_type        chain_ctl     [NORM_BITS+1];
   logic [RAW_W-1:0]    chain_divisor [NORM_BITS+1];
   logic [REM_W-1:0]    chain_rem     [NORM_BITS+1][CHANNELS];
   logic [NORM_BITS-1:0] chain_quot   [NORM_BITS+1][CHANNELS];

   logic [NORM_BITS-1:0] norm [CHANNELS];
   class_type            match_class;
   rsp_word_type         m_word_in;
   rsp_word_type         m_word_ff;
   logic                 m_valid_ff;

   // output register and skid
   logic                 take;
   logic                 out_valid_ff;
   rsp_word_type         out_word_ff;
   logic                 skid_full_ff;
   rsp_word_type         skid_word_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         for (int i = 0; i < NUM_REFERENCES; i++) begin
            ref_ff[i] <= REF_RESET[i];
         end
      end else if (csr_valid) begin
         if (csr_index == REG_MARGIN) begin
            margin_ff <= csr_data[MARGIN_W-1:0];
         end
         for (int i = 0; i < NUM_REFERENCES; i++) begin
            if (csr_index == REG_ORANGE + CSR_INDEX_W'(i)) begin
               ref_ff[i] <= csr_data;
            end
         end
      end
   end

   always_comb begin
      scale_lo = 9'd256 - 9'(margin_ff);
      scale_hi = 9'd256 + 9'(margin_ff);
      for (int i = 0; i < NUM_REFERENCES; i++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            lo_in[i][c] = BOUND_W'(ref_ff[i][BYTE_W*(CHANNELS-1-c) +: BYTE_W])
                          * BOUND_W'(scale_lo);
            hi_in[i][c] = BOUND_W'(ref_ff[i][BYTE_W*(CHANNELS-1-c) +: BYTE_W])
                          * BOUND_W'(scale_hi);
         end
      end
   end

   // bounds follow the registers in the next cycle
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // ---------------- front stages ----------------
   assign advance   = !skid_full_ff;
   assign req_stall = skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_ctl_ff   <= '0;
         m_valid_ff  <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_ctl_ff   <= s2_ctl_in;
         m_valid_ff  <= chain_ctl[NORM_BITS].valid;
      end
   end

   assign div_prod = (RAW_W+RECIP_W)'(s0_clear_ff) * (RAW_W+RECIP_W)'(DIV_RECIP);

   always_comb begin
      s2_ctl_in.valid = s1_valid_ff;
      s2_ctl_in.zero  = s1_divisor_ff == '0;
      for (int c = 0; c < CHANNELS; c++) begin
         s2_rem_in[c] = {s1_chan_ff[c], {BYTE_W{1'b0}}};
         // quotient would not fit in NORM_BITS: clamp later
         s2_ctl_in.sat[c] = SHW'(s2_rem_in[c]) >= (SHW'(s1_divisor_ff) << NORM_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_chan_ff[0] <= req_raw_red;
         s0_chan_ff[1] <= req_raw_green;
         s0_chan_ff[2] <= req_raw_blue;
         s0_clear_ff   <= req_raw_clear;
         s1_chan_ff    <= s0_chan_ff;
         s1_divisor_ff <= div_prod[DIV_SHIFT +: RAW_W];
         s2_divisor_ff <= s1_divisor_ff;
         s2_rem_ff     <= s2_rem_in;
         m_word_ff     <= m_word_in;
      end
   end

   // ---------------- divider chain ----------------
   assign chain_ctl[0]     = s2_ctl_ff;
   assign chain_divisor[0] = s2_divisor_ff;
   assign chain_rem[0]     = s2_rem_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         chain_quot[0][c] = '0;
      end
   end

   for (genvar k = 0; k < NORM_BITS; k++) begin : g_cell
      rcwc_div_cell #(
         .NORM_BITS (NORM_BITS),
         .STEP      (NORM_BITS - 1 - k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .up_ctl     (chain_ctl[k]),
         .up_divisor (chain_divisor[k]),
         .up_rem     (chain_rem[k]),
         .up_quot    (chain_quot[k]),
         .dn_ctl     (chain_ctl[k+1]),
         .dn_divisor (chain_divisor[k+1]),
         .dn_rem     (chain_rem[k+1]),
         .dn_quot    (chain_quot[k+1])
      );
   end

   // ---------------- match stage ----------------
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         norm[c] = chain_ctl[NORM_BITS].sat[c] ? '1 : chain_quot[NORM_BITS][c];
      end
   end

   rcwc_match #(
      .NUM_REFERENCES (NUM_REFERENCES),
      .NORM_BITS      (NORM_BITS)
   ) u_match (
      .norm        (norm),
      .bound_lo    (lo_ff),
      .bound_hi    (hi_ff),
      .color_class (match_class)
   );

   always_comb begin
      if (chain_ctl[NORM_BITS].zero) begin
         m_word_in.color_class  = CLS_NONE;
         m_word_in.norm_red     = '0;
         m_word_in.norm_green   = '0;
         m_word_in.norm_blue    = '0;
         m_word_in.zero_divisor = 1'b1;
      end else begin
         m_word_in.color_class  = match_class;
         m_word_in.norm_red     = OUT_NORM_W'(norm[0]);
         m_word_in.norm_green   = OUT_NORM_W'(norm[1]);
         m_word_in.norm_blue    = OUT_NORM_W'(norm[2]);
         m_word_in.zero_divisor = 1'b0;
      end
   end

   // ---------------- output register and skid ----------------
   assign take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= m_valid_ff;
      end else if (m_valid_ff) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) begin
            out_word_ff <= skid_word_ff;
         end
      end else if (!out_valid_ff || take) begin
         out_word_ff <= m_word_ff;
      end else begin
         // park the word while the receiver holds
         skid_word_ff <= m_word_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_color_class  = out_word_ff.color_class;
   assign rsp_norm_red     = out_word_ff.norm_red;
   assign rsp_norm_green   = out_word_ff.norm_green;
   assign rsp_norm_blue    = out_word_ff.norm_blue;
   assign rsp_zero_divisor = out_word_ff.zero_divisor;

endmodule

`default_nettype wire

// ===== sv/rcwc_chk.sv =====
// Port-level checker for the RGB color window classifier, bound to the top level.
`default_nettype none

module rcwc_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [2:0]                        rsp_color_class,
   input logic [rcwc_pkg::OUT_NORM_W-1:0]   rsp_norm_red,
   input logic [rcwc_pkg::OUT_NORM_W-1:0]   rsp_norm_green,
   input logic [rcwc_pkg::OUT_NORM_W-1:0]   rsp_norm_blue,
   input logic                              rsp_zero_divisor
);
   import rcwc_pkg::*;

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_color_class) && $stable(rsp_norm_red)
         && $stable(rsp_norm_green) && $stable(rsp_norm_blue)
         && $stable(rsp_zero_divisor))
      else $error("result word changed while stalled");

   a_zero_divisor_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |-> rsp_color_class == CLS_NONE
         && rsp_norm_red == '0 && rsp_norm_green == '0 && rsp_norm_blue == '0)
      else $error("zero divisor word carries a class or channel values");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a held result word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind rgb_color_window_classifier rcwc_chk u_rcwc_chk (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_color_class  (rsp_color_class),
   .rsp_norm_red     (rsp_norm_red),
   .rsp_norm_green   (rsp_norm_green),
   .rsp_norm_blue    (rsp_norm_blue),
   .rsp_zero_divisor (rsp_zero_divisor)
);

`default_nettype wire

// ===== bench/color_window_checker.sv =====
// Scoreboard for the color window classifier: mirrors the registers, predicts and checks each word.
`timescale 1ns / 1ps

module color_window_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [rcwc_pkg::RAW_W-1:0]       req_raw_red,
   input  logic [rcwc_pkg::RAW_W-1:0]       req_raw_green,
   input  logic [rcwc_pkg::RAW_W-1:0]       req_raw_blue,
   input  logic [rcwc_pkg::RAW_W-1:0]       req_raw_clear,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [2:0]                       rsp_color_class,
   input  logic [rcwc_pkg::OUT_NORM_W-1:0]  rsp_norm_red,
   input  logic [rcwc_pkg::OUT_NORM_W-1:0]  rsp_norm_green,
   input  logic [rcwc_pkg::OUT_NORM_W-1:0]  rsp_norm_blue,
   input  logic                             rsp_zero_divisor,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [rcwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcwc_pkg::REF_W-1:0]       csr_data,
   output int                               error_count,
   output int                               words_pending
);
   import rcwc_pkg::*;

   localparam int NORM_MAX  = (1 << NORM_BITS_DEF) - 1;

   logic [MARGIN_W-1:0] margin_now;
   ref_type             refs_now [MAX_REFERENCES];
   rsp_word_type        expected_words [$];

   initial begin
      error_count   = 0;
      words_pending = 0;
   end

   // exact rational window: r*(256-m) <= v*256 <= r*(256+m)
   function automatic bit window_hit(int v, int rb, int m);
      return (rb * (256 - m) <= v * 256) && (v * 256 <= rb * (256 + m));
   endfunction

   function automatic rsp_word_type classify_reading(logic [RAW_W-1:0] r, logic [RAW_W-1:0] g,
                                                     logic [RAW_W-1:0] b, logic [RAW_W-1:0] c);
      rsp_word_type w;
      int           divisor;
      int           level [CHANNELS];
      ref_type      rf;
      w = '0;
      divisor = int'(c);
      divisor = divisor * 9 / 10;
      if (divisor == 0) begin
         w.zero_divisor = 1'b1;
         return w;
      end
      level[0] = int'(r);
      level[1] = int'(g);
      level[2] = int'(b);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         level[ch] = level[ch] * 256 / divisor;
         if (level[ch] > NORM_MAX) level[ch] = NORM_MAX;
      end
      w.norm_red   = OUT_NORM_W'(level[0]);
      w.norm_green = OUT_NORM_W'(level[1]);
      w.norm_blue  = OUT_NORM_W'(level[2]);
      // first reference in priority order wins
      for (int k = 0; k < NUM_REFERENCES_DEF; k++) begin
         rf = refs_now[k];
         if (w.color_class == CLS_NONE &&
             window_hit(level[0], int'(rf[23:16]), int'(margin_now)) &&
             window_hit(level[1], int'(rf[15:8]), int'(margin_now)) &&
             window_hit(level[2], int'(rf[7:0]), int'(margin_now))) begin
            w.color_class = CLASS_CODE[k];
         end
      end
      return w;
   endfunction

   task automatic note_mismatch(string field, int want, int got);
      error_count++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         margin_now = MARGIN_RESET;
         refs_now   = REF_RESET;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               error_count++;
               $display("%0t unexpected word: expected none, actual class %0d norm %0d/%0d/%0d",
                        $time, rsp_color_class, rsp_norm_red, rsp_norm_green,
                        rsp_norm_blue);
            end else begin
               want = expected_words.pop_front();
               if (rsp_color_class !== want.color_class)
                  note_mismatch("color_class", int'(want.color_class), int'(rsp_color_class));
               if (rsp_norm_red !== want.norm_red)
                  note_mismatch("norm_red", int'(want.norm_red), int'(rsp_norm_red));
               if (rsp_norm_green !== want.norm_green)
                  note_mismatch("norm_green", int'(want.norm_green), int'(rsp_norm_green));
               if (rsp_norm_blue !== want.norm_blue)
                  note_mismatch("norm_blue", int'(want.norm_blue), int'(rsp_norm_blue));
               if (rsp_zero_divisor !== want.zero_divisor)
                  note_mismatch("zero_divisor", int'(want.zero_divisor),
                                int'(rsp_zero_divisor));
            end
         end
         if (req_valid && !req_stall)
            expected_words.push_back(classify_reading(req_raw_red, req_raw_green,
                                                      req_raw_blue, req_raw_clear));
         if (csr_valid && csr_ready) begin
            // indexes past the black reference are dropped by the block
            if (csr_index == REG_MARGIN)
               margin_now = csr_data[MARGIN_W-1:0];
            else if (csr_index <= REG_BLACK)
               refs_now[csr_index - REG_ORANGE] = csr_data;
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the color window classifier bench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps

module tb_top;
   import rcwc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] UNUSED_INDEX = 3'd7;
   localparam int EDGE_CLEAR = 285;   // divisor 256: normalized value equals the raw count
   localparam int LATENCY    = NORM_BITS_DEF + 4;
   localparam int PHASES     = 9;
   localparam int PHASE_LEN  = 200;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [RAW_W-1:0]       req_raw_red;
   logic [RAW_W-1:0]       req_raw_green;
   logic [RAW_W-1:0]       req_raw_blue;
   logic [RAW_W-1:0]       req_raw_clear;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [2:0]             rsp_color_class;
   logic [OUT_NORM_W-1:0]  rsp_norm_red;
   logic [OUT_NORM_W-1:0]  rsp_norm_green;
   logic [OUT_NORM_W-1:0]  rsp_norm_blue;
   logic                   rsp_zero_divisor;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REF_W-1:0]       csr_data;

   int                     error_count;
   int                     words_pending;
   int                     gap_pct;
   int                     stall_pct;
   logic [MARGIN_W-1:0]    margin_set;
   ref_type                ref_set [MAX_REFERENCES];

   rgb_color_window_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_red      (req_raw_red),
      .req_raw_green    (req_raw_green),
      .req_raw_blue     (req_raw_blue),
      .req_raw_clear    (req_raw_clear),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_class  (rsp_color_class),
      .rsp_norm_red     (rsp_norm_red),
      .rsp_norm_green   (rsp_norm_green),
      .rsp_norm_blue    (rsp_norm_blue),
      .rsp_zero_divisor (rsp_zero_divisor),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   color_window_checker monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_red      (req_raw_red),
      .req_raw_green    (req_raw_green),
      .req_raw_blue     (req_raw_blue),
      .req_raw_clear    (req_raw_clear),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_class  (rsp_color_class),
      .rsp_norm_red     (rsp_norm_red),
      .rsp_norm_green   (rsp_norm_green),
      .rsp_norm_blue    (rsp_norm_blue),
      .rsp_zero_divisor (rsp_zero_divisor),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .words_pending    (words_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // a value just outside, on, or just inside the window edges of one reference byte
   function automatic int window_probe(int rb, int m, int side);
      int lo;
      int hi;
      lo = (rb * (256 - m) + 255) / 256;
      hi = rb * (256 + m) / 256;
      case (side)
         0: return (lo > 0) ? lo - 1 : 0;
         1: return lo;
         2: return hi;
         default: return hi + 1;
      endcase
   endfunction

   // hold the word until the block takes it
   task automatic offer_reading(logic [RAW_W-1:0] r, logic [RAW_W-1:0] g,
                                logic [RAW_W-1:0] b, logic [RAW_W-1:0] c);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_red   <= r;
      req_raw_green <= g;
      req_raw_blue  <= b;
      req_raw_clear <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [REF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic run_phase(int count);
      int               pick;
      int               k;
      int               ch;
      int               m;
      int               d;
      int               rb;
      int               j;
      int               v;
      int               rw;
      logic [RAW_W-1:0] raw [4];
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         m    = int'(margin_set);
         k    = $urandom_range(MAX_REFERENCES - 1);
         if (pick < 55) begin
            // aim each channel near the chosen reference, around its window
            raw[3] = RAW_W'($urandom_range(18000, 2));
            d = int'(raw[3]);
            d = d * 9 / 10;
            for (ch = 0; ch < CHANNELS; ch++) begin
               rb = int'(ref_set[k][8 * (2 - ch) +: 8]);
               j  = $urandom_range(2 * m + 16);
               j  = j - (m + 8);
               v  = rb * (256 + j) / 256;
               if (v < 0) v = 0;
               rw = (v * d + 255) / 256;
               if (rw > 65535) rw = 65535;
               raw[ch] = RAW_W'(rw);
            end
         end else if (pick < 65) begin
            // divisor of zero or near it
            for (ch = 0; ch < CHANNELS; ch++) raw[ch] = RAW_W'($urandom_range(65535));
            raw[3] = RAW_W'($urandom_range(3));
         end else if (pick < 80) begin
            for (ch = 0; ch < CHANNELS; ch++) raw[ch] = RAW_W'(ref_set[k][8 * (2 - ch) +: 8]);
            ch = $urandom_range(CHANNELS - 1);
            raw[ch] = RAW_W'(window_probe(int'(ref_set[k][8 * (2 - ch) +: 8]), m,
                                          $urandom_range(3)));
            raw[3] = RAW_W'(EDGE_CLEAR);
         end else begin
            for (ch = 0; ch < 4; ch++) begin
               rw = $urandom_range(65535);
               if ($urandom_range(1)) rw = rw >> $urandom_range(15);
               raw[ch] = RAW_W'(rw);
            end
         end
         offer_reading(raw[0], raw[1], raw[2], raw[3]);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int unsigned spare;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_raw_red   = '0;
      req_raw_green = '0;
      req_raw_blue  = '0;
      req_raw_clear = '0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = REG_MARGIN;
      csr_data      = '0;
      gap_pct       = 0;
      stall_pct     = 0;
      margin_set    = MARGIN_RESET;
      ref_set       = REF_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero divisor, saturation, field extremes, exact hits, window edges
      offer_reading(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      offer_reading(16'h04D2, 16'hFFFF, 16'h0001, 16'h0001);
      offer_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0002);
      offer_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_reading(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      offer_reading(16'hFFFF, 16'h0000, 16'h00FF, 16'h012C);
      offer_reading(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      for (int k = 0; k < MAX_REFERENCES; k++)
         offer_reading(RAW_W'(ref_set[k][23:16]), RAW_W'(ref_set[k][15:8]),
                       RAW_W'(ref_set[k][7:0]), RAW_W'(EDGE_CLEAR));
      for (int side = 0; side < 4; side++)
         offer_reading(RAW_W'(window_probe(int'(ref_set[CLS_WHITE - CLS_ORANGE][23:16]),
                                           int'(margin_set), side)),
                       RAW_W'(ref_set[CLS_WHITE - CLS_ORANGE][15:8]),
                       RAW_W'(ref_set[CLS_WHITE - CLS_ORANGE][7:0]), RAW_W'(EDGE_CLEAR));
      req_valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            // block is idle here: every word of the previous phase has come back
            case (phase)
               1: begin
                  margin_set = '0;
                  foreach (ref_set[k]) ref_set[k] = REF_W'($urandom);
               end
               2: begin
                  margin_set = 8'hFF;
                  foreach (ref_set[k]) ref_set[k] = REF_W'($urandom);
               end
               3: begin
                  margin_set = MARGIN_W'($urandom);
                  ref_set = '{24'h000000, 24'hFFFFFF, 24'hFF00FF,
                              24'h00FF00, 24'h000000, 24'hFFFFFF};
               end
               PHASES - 1: begin
                  margin_set = MARGIN_RESET;
                  ref_set    = REF_RESET;
               end
               default: begin
                  margin_set = MARGIN_W'($urandom);
                  foreach (ref_set[k]) ref_set[k] = REF_W'($urandom);
               end
            endcase
            spare = $urandom;
            csr_write(REG_MARGIN, {spare[15:0], margin_set});
            foreach (ref_set[k]) csr_write(CSR_INDEX_W'(REG_ORANGE + k), ref_set[k]);
            if (phase == 4) csr_write(UNUSED_INDEX, REF_W'($urandom));
            csr_valid <= 1'b0;
         end
         @(posedge clock);
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 52; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 52; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         @(negedge clock);
         run_phase(PHASE_LEN);
         wait_drained();
      end

      repeat (2 * LATENCY) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
